// ----- rtl/lffs_pkg.sv -----
// Package for the length-field frame splitter: configuration record,
// register indexes, mode codes and reset values.
// No dependencies.
package lffs_pkg;

    // Framing mode codes
    localparam logic MODE_FIXED        = 1'b0;
    localparam logic MODE_LENGTH_FIELD = 1'b1;

    // Byte order code for the length field
    localparam logic ORDER_LITTLE_ENDIAN = 1'b1;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_FRAMING_MODE    = 3'd0,
        REG_FIXED_LENGTH    = 3'd1,
        REG_FIELD_OFFSET    = 3'd2,
        REG_FIELD_BYTES     = 3'd3,
        REG_LITTLE_ENDIAN   = 3'd4,
        REG_INCLUDES_HEADER = 3'd5,
        REG_HEADER_BYTES    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        framing_mode;
        logic [15:0] fixed_length;
        logic [7:0]  field_offset;
        logic [2:0]  field_bytes;
        logic        little_endian;
        logic        includes_header;
        logic [7:0]  header_bytes;
    } cfg_t;

    localparam logic        RST_FRAMING_MODE    = MODE_FIXED;
    localparam logic [15:0] RST_FIXED_LENGTH    = 16'd1;
    localparam logic [7:0]  RST_FIELD_OFFSET    = 8'd0;
    localparam logic [2:0]  RST_FIELD_BYTES     = 3'd2;
    localparam logic        RST_LITTLE_ENDIAN   = 1'b0;
    localparam logic        RST_INCLUDES_HEADER = 1'b0;
    localparam logic [7:0]  RST_HEADER_BYTES    = 8'd0;

endpackage

// ----- rtl/lffs_frame_core.sv -----
// Frame tracking core: byte counter, length-field gather and frame end flag.
// Depends on lffs_pkg (cfg_t, mode and byte order codes).
module lffs_frame_core #(
    parameter int MAX_FIELD_BYTES = 4,
    parameter int COUNT_BITS      = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lffs_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output logic          frame_end
);
    import lffs_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [3:0]            MAX_FB    = 4'(MAX_FIELD_BYTES);

    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [31:0]           length_accum_reg, length_accum_next;
    logic [COUNT_BITS-1:0] frame_total_reg, frame_total_next;
    logic                  header_done_reg, header_done_next;

    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] pos;
    logic [15:0]           flen;
    logic [3:0]            fb;
    logic [8:0]            min_header;
    logic                  in_field;
    logic [COUNT_BITS-1:0] idx_full;
    logic [2:0]            idx;
    logic [31:0]           accum_g;
    logic [32:0]           total;
    logic [COUNT_BITS-1:0] total_sat;
    logic                  end_c;

    always_comb
    begin
        count_inc = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 1'b1 : byte_count_reg;
        pos       = count_inc - 1'b1;
        flen      = (cfg.fixed_length == 16'd0) ? 16'd1 : cfg.fixed_length;

        fb = {1'b0, cfg.field_bytes};
        if (fb == 4'd0)
            fb = 4'd1;
        if (fb > MAX_FB)
            fb = MAX_FB;
        min_header = {1'b0, cfg.field_offset} + {5'b0, fb};

        in_field = (pos >= COUNT_BITS'(cfg.field_offset)) &&
                   (pos <  COUNT_BITS'(min_header));
        idx_full = pos - COUNT_BITS'(cfg.field_offset);
        idx      = idx_full[2:0];

        // Gather one length byte; overflow past 32 bits saturates
        accum_g = length_accum_reg;
        if (in_field)
        begin
            if (cfg.little_endian == ORDER_LITTLE_ENDIAN)
            begin
                if (idx < 3'd4)
                    accum_g = length_accum_reg | ({24'b0, rx_byte} << {idx[1:0], 3'b000});
                else if (rx_byte != 8'd0)
                    accum_g = 32'hFFFF_FFFF;
            end
            else
            begin
                if (length_accum_reg[31:24] != 8'd0)
                    accum_g = 32'hFFFF_FFFF;
                else
                    accum_g = {length_accum_reg[23:0], rx_byte};
            end
        end

        total = {1'b0, accum_g} +
                (cfg.includes_header ? 33'd0 : {25'b0, cfg.header_bytes});
        total_sat = (total > {{(33-COUNT_BITS){1'b0}}, COUNT_MAX}) ?
                    COUNT_MAX : total[COUNT_BITS-1:0];

        byte_count_next   = count_inc;
        length_accum_next = length_accum_reg;
        frame_total_next  = frame_total_reg;
        header_done_next  = header_done_reg;
        end_c             = 1'b0;

        if (cfg.framing_mode == MODE_FIXED)
        begin
            end_c = (count_inc >= COUNT_BITS'(flen));
        end
        else if (!header_done_reg)
        begin
            length_accum_next = accum_g;
            if (count_inc >= COUNT_BITS'(min_header))
            begin
                frame_total_next = total_sat;
                header_done_next = 1'b1;
                end_c            = (total_sat <= count_inc);
            end
        end
        else
        begin
            end_c = (count_inc >= frame_total_reg);
        end

        if (end_c)
        begin
            byte_count_next   = '0;
            length_accum_next = '0;
            frame_total_next  = '0;
            header_done_next  = 1'b0;
        end
    end

    assign frame_end = end_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            length_accum_reg <= '0;
            frame_total_reg  <= '0;
            header_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            byte_count_reg   <= byte_count_next;
            length_accum_reg <= length_accum_next;
            frame_total_reg  <= frame_total_next;
            header_done_reg  <= header_done_next;
        end
    end

    // A closed frame leaves the counter at zero
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (byte_count_reg == '0 && !header_done_reg))
        else $error("frame end did not clear frame state");

    // Total length is only held once the header is complete
    a_total_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        !header_done_reg |-> (frame_total_reg == '0))
        else $error("frame total set without header");

endmodule

// ----- rtl/length_field_frame_splitter_unit.sv -----
// Top level of the length-field frame splitter: APB register file,
// frame core and output skid stage. Depends on lffs_pkg, lffs_frame_core.
//
// Usage:
//   Bytes enter on the s_* stream (s_tdata = rx_byte) and leave unchanged on
//   the m_* stream (m_tdata = data_byte) with m_tlast marking the last byte
//   of each frame. Fixed mode cuts every fixed_length bytes; length-field
//   mode reads a 1..MAX_FIELD_BYTES byte length from the header and cuts
//   when the total frame length is reached.
//   Registers sit on the APB port at byte address 4*index; pready is
//   always high, writes land on the access cycle. Write them while idle.
// Throughput and datapath:
//   One byte per cycle unless the sink stalls. An accepted byte is registered
//   (via the skid when stalled) for m_*; the frame decision, one increment,
//   a byte gather, one 33-bit add and compares, is a single stage.
// Stall:
//   A main output register plus a one-entry skid register. When the sink
//   stalls, one more byte is still taken into the skid; s_tready then drops
//   until the sink takes a transaction. No data is lost or repeated.
// Reset:
//   rst_n (async, active low) restores register defaults, clears frame
//   state and empties both output stages.
module length_field_frame_splitter_unit #(
    parameter int MAX_FIELD_BYTES = 4,
    parameter int COUNT_BITS      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic        m_tlast    // frame_end
);
    import lffs_pkg::*;

    cfg_t        cfg_reg;
    logic [2:0]  reg_index;
    logic        cfg_write;

    logic        s_accept;
    logic        frame_end;

    // Output register and skid stage
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic        skid_valid_reg;
    logic [7:0]  skid_data_reg;
    logic        skid_last_reg;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.framing_mode    <= RST_FRAMING_MODE;
            cfg_reg.fixed_length    <= RST_FIXED_LENGTH;
            cfg_reg.field_offset    <= RST_FIELD_OFFSET;
            cfg_reg.field_bytes     <= RST_FIELD_BYTES;
            cfg_reg.little_endian   <= RST_LITTLE_ENDIAN;
            cfg_reg.includes_header <= RST_INCLUDES_HEADER;
            cfg_reg.header_bytes    <= RST_HEADER_BYTES;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_FRAMING_MODE:    cfg_reg.framing_mode    <= pwdata[0];
                REG_FIXED_LENGTH:    cfg_reg.fixed_length    <= pwdata[15:0];
                REG_FIELD_OFFSET:    cfg_reg.field_offset    <= pwdata[7:0];
                REG_FIELD_BYTES:     cfg_reg.field_bytes     <= pwdata[2:0];
                REG_LITTLE_ENDIAN:   cfg_reg.little_endian   <= pwdata[0];
                REG_INCLUDES_HEADER: cfg_reg.includes_header <= pwdata[0];
                REG_HEADER_BYTES:    cfg_reg.header_bytes    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux, zero extended
    always_comb
    begin
        case (reg_index)
            REG_FRAMING_MODE:    prdata = {31'b0, cfg_reg.framing_mode};
            REG_FIXED_LENGTH:    prdata = {16'b0, cfg_reg.fixed_length};
            REG_FIELD_OFFSET:    prdata = {24'b0, cfg_reg.field_offset};
            REG_FIELD_BYTES:     prdata = {29'b0, cfg_reg.field_bytes};
            REG_LITTLE_ENDIAN:   prdata = {31'b0, cfg_reg.little_endian};
            REG_INCLUDES_HEADER: prdata = {31'b0, cfg_reg.includes_header};
            REG_HEADER_BYTES:    prdata = {24'b0, cfg_reg.header_bytes};
            default:             prdata = 32'd0;
        endcase
    end

    // Input is open as long as the skid slot is free
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    lffs_frame_core #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .COUNT_BITS      (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (s_accept),
        .rx_byte   (s_tdata),
        .frame_end (frame_end)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
            begin
                // Output slot frees up: drain skid first, else take new byte
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    out_last_reg   <= skid_last_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= s_accept;
                    out_data_reg  <= s_tdata;
                    out_last_reg  <= frame_end;
                end
            end
            else if (s_accept)
            begin
                // Sink stalled: park the new transaction in the skid
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= s_tdata;
                skid_last_reg  <= frame_end;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output empty");

    // Skid content moves to the output once the sink takes a transaction
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain");

endmodule
